>>> hw/rtl/npe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-body energy package
// Types, command and status groups and constants shared by the energy block.
// ----------------------------------------------------------------------------
package npe_pkg;

  localparam int unsigned StepW     = 6;
  localparam int unsigned SqSteps   = 3;
  localparam int unsigned SqrtSteps = 34;
  localparam int unsigned DivSteps  = 48;
  localparam int unsigned MulSteps  = 4;

  localparam logic [31:0] GravReset = 32'h0001_0000;
  localparam logic [47:0] PotLimit  = 48'h8000_0000_0000;

  typedef struct packed {
    logic [31:0]        mass;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        speed_sq;
    logic               last_particle;
  } npe_in_t;

  typedef struct packed {
    logic [47:0]        kinetic;
    logic signed [47:0] potential;
    logic               saturated;
    logic               last_result;
  } npe_out_t;

  typedef struct packed {
    logic [31:0] mass;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] speed_sq;
  } npe_rec_t;

  typedef struct packed {
    logic             lat_i;
    logic             lat_j;
    logic             sq_en;
    logic             coinc_set;
    logic             sqrt_init;
    logic             sqrt_en;
    logic             div_init;
    logic             div_en;
    logic             acc_en;
    logic             gm_en;
    logic             mul_en;
    logic             emit;
    logic             last;
    logic [StepW-1:0] step;
  } npe_cmd_t;

  typedef struct packed {
    logic sos_zero;
    logic out_free;
  } npe_status_t;

  function automatic logic [32:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    return d[32] ? (~d + 33'd1) : d;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/npe_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module npe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

>>> hw/rtl/npe_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-body energy controller
// Sequences loading, pair iteration and result emission.
// ----------------------------------------------------------------------------
module npe_ctrl
  import npe_pkg::*;
#(
  parameter int unsigned MaxParticles = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  input  wire logic                            in_last_i,
  output      logic                            in_stall_o,
  output      logic                            wr_en_o,
  output      logic [$clog2(MaxParticles)-1:0] wr_addr_o,
  output      logic [$clog2(MaxParticles)-1:0] rd_addr_o,
  output      npe_cmd_t                        cmd_o,
  input  wire npe_status_t                     status_i
);

  localparam int unsigned IdxW = $clog2(MaxParticles);
  localparam int unsigned CntW = $clog2(MaxParticles + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MaxParticles);

  typedef enum logic [13:0] {
    StLoad = 14'b00000000000001,
    StRdI  = 14'b00000000000010,
    StLatI = 14'b00000000000100,
    StRdJ  = 14'b00000000001000,
    StLatJ = 14'b00000000010000,
    StSq   = 14'b00000000100000,
    StChk  = 14'b00000001000000,
    StSqrt = 14'b00000010000000,
    StDvi  = 14'b00000100000000,
    StDiv  = 14'b00001000000000,
    StAcc  = 14'b00010000000000,
    StFin  = 14'b00100000000000,
    StMul  = 14'b01000000000000,
    StEmit = 14'b10000000000000
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  n_q, n_d;
  logic [IdxW-1:0]  i_q, i_d;
  logic [CntW-1:0]  j_q, j_d;
  logic [StepW-1:0] step_q, step_d;
  logic             in_acc;

  assign in_acc     = in_valid_i && (state_q == StLoad);
  assign in_stall_o = (state_q != StLoad);
  assign wr_en_o    = in_acc;
  assign wr_addr_o  = n_q[IdxW-1:0];
  assign rd_addr_o  = (state_q == StRdI) ? i_q : j_q[IdxW-1:0];

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    i_d     = i_q;
    j_d     = j_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    cmd_o.last = (CntW'(i_q) + CntW'(1)) == n_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          n_d = n_q + CntW'(1);
          if (in_last_i || (n_q + CntW'(1)) == MaxCnt) begin
            i_d     = '0;
            state_d = StRdI;
          end
        end
      end
      StRdI: begin
        state_d = StLatI;
      end
      StLatI: begin
        cmd_o.lat_i = 1'b1;
        j_d         = '0;
        state_d     = StRdJ;
      end
      StRdJ: begin
        if (j_q == n_q) begin
          state_d = StFin;
        end else if (j_q[IdxW-1:0] == i_q) begin
          j_d = j_q + CntW'(1);
        end else begin
          j_d     = j_q + CntW'(1);
          step_d  = '0;
          state_d = StLatJ;
        end
      end
      StLatJ: begin
        cmd_o.lat_j = 1'b1;
        state_d     = StSq;
      end
      StSq: begin
        cmd_o.sq_en = 1'b1;
        step_d      = step_q + StepW'(1);
        if (step_q == StepW'(SqSteps - 1)) begin
          state_d = StChk;
        end
      end
      StChk: begin
        step_d = '0;
        if (status_i.sos_zero) begin
          cmd_o.coinc_set = 1'b1;
          state_d         = StRdJ;
        end else begin
          cmd_o.sqrt_init = 1'b1;
          state_d         = StSqrt;
        end
      end
      StSqrt: begin
        cmd_o.sqrt_en = 1'b1;
        step_d        = step_q + StepW'(1);
        if (step_q == StepW'(SqrtSteps - 1)) begin
          state_d = StDvi;
        end
      end
      StDvi: begin
        cmd_o.div_init = 1'b1;
        step_d         = '0;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_en = 1'b1;
        step_d       = step_q + StepW'(1);
        if (step_q == StepW'(DivSteps - 1)) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        cmd_o.acc_en = 1'b1;
        state_d      = StRdJ;
      end
      StFin: begin
        cmd_o.gm_en = 1'b1;
        step_d      = '0;
        state_d     = StMul;
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        step_d       = step_q + StepW'(1);
        if (step_q == StepW'(MulSteps - 1)) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if ((CntW'(i_q) + CntW'(1)) == n_q) begin
            n_d     = '0;
            state_d = StLoad;
          end else begin
            i_d     = i_q + IdxW'(1);
            state_d = StRdI;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      n_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      i_q     <= i_d;
      j_q     <= j_d;
      step_q  <= step_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("Result emitted while the output register was occupied.");

  a_no_self_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRdJ && state_d == StLatJ) |-> (j_q[IdxW-1:0] != i_q))
    else $error("A particle was paired with itself.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= MaxCnt)
    else $error("Particle count exceeds the store depth.");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/npe_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-body energy datapath
// Distance, square root, division, accumulation, multiplication and the output register.
// ----------------------------------------------------------------------------
module npe_dp
  import npe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire npe_rec_t    rdata_i,
  input  wire npe_cmd_t    cmd_i,
  output      npe_status_t status_o,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      npe_out_t    out_o
);

  logic [31:0]  grav_q;
  logic [31:0]  mi_q, xi_q, yi_q, zi_q, mj_q;
  logic [47:0]  kin_q;
  logic [32:0]  dx_q, dy_q, dz_q;
  logic [67:0]  sos_q;
  logic [67:0]  rad_q;
  logic [35:0]  srem_q;
  logic [33:0]  root_q;
  logic [47:0]  num_q;
  logic [33:0]  drem_q;
  logic [47:0]  quo_q;
  logic [53:0]  sum_q;
  logic         coinc_q;
  logic [63:0]  gm_q;
  logic [117:0] prod_q;
  logic         out_valid_q;
  npe_out_t     out_q;

  logic [32:0]  sq_sel;
  logic [37:0]  srem_t, strial;
  logic         sge;
  logic [34:0]  drem_t;
  logic         dge;
  logic [31:0]  ma, mb;
  logic [63:0]  pp;
  logic [117:0] pp_sh;
  logic         sat;
  logic [47:0]  mag;

  assign status_o.sos_zero = (sos_q == '0);
  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign out_o             = out_q;

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0:    sq_sel = dx_q;
      2'd1:    sq_sel = dy_q;
      default: sq_sel = dz_q;
    endcase
  end

  assign srem_t = {srem_q, rad_q[67:66]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = srem_t >= strial;
  assign drem_t = {drem_q, num_q[47]};
  assign dge    = drem_t >= {1'b0, root_q};

  always_comb begin
    case (cmd_i.step[1:0])
      2'd0: begin
        ma = gm_q[31:0];
        mb = sum_q[31:0];
      end
      2'd1: begin
        ma = gm_q[31:0];
        mb = {10'd0, sum_q[53:32]};
      end
      2'd2: begin
        ma = gm_q[63:32];
        mb = sum_q[31:0];
      end
      default: begin
        ma = gm_q[63:32];
        mb = {10'd0, sum_q[53:32]};
      end
    endcase
    pp = ma * mb;
    case (cmd_i.step[1:0])
      2'd0:    pp_sh = 118'(pp);
      2'd3:    pp_sh = 118'(pp) << 64;
      default: pp_sh = 118'(pp) << 32;
    endcase
  end

  assign sat = coinc_q || (|prod_q[117:96]) || (prod_q[95:32] > 64'(PotLimit));
  assign mag = sat ? PotLimit : prod_q[79:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q      <= GravReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grav_q <= cfg_wdata_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lat_i) begin
      mi_q    <= rdata_i.mass;
      xi_q    <= rdata_i.pos_x;
      yi_q    <= rdata_i.pos_y;
      zi_q    <= rdata_i.pos_z;
      kin_q   <= 48'((64'(rdata_i.mass) * 64'(rdata_i.speed_sq)) >> 17);
      sum_q   <= '0;
      coinc_q <= 1'b0;
    end
    if (cmd_i.lat_j) begin
      mj_q <= rdata_i.mass;
      dx_q <= abs_diff(xi_q, rdata_i.pos_x);
      dy_q <= abs_diff(yi_q, rdata_i.pos_y);
      dz_q <= abs_diff(zi_q, rdata_i.pos_z);
    end
    if (cmd_i.sq_en) begin
      sos_q <= ((cmd_i.step == '0) ? 68'd0 : sos_q) + 68'(66'(sq_sel) * 66'(sq_sel));
    end
    if (cmd_i.coinc_set) begin
      coinc_q <= 1'b1;
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= sos_q;
      srem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt_en) begin
      rad_q  <= rad_q << 2;
      srem_q <= 36'(sge ? (srem_t - strial) : srem_t);
      root_q <= {root_q[32:0], sge};
    end
    if (cmd_i.div_init) begin
      num_q  <= {mj_q, 16'd0};
      drem_q <= '0;
      quo_q  <= '0;
    end
    if (cmd_i.div_en) begin
      num_q  <= num_q << 1;
      drem_q <= 34'(dge ? (drem_t - {1'b0, root_q}) : drem_t);
      quo_q  <= {quo_q[46:0], dge};
    end
    if (cmd_i.acc_en) begin
      sum_q <= sum_q + 54'(quo_q);
    end
    if (cmd_i.gm_en) begin
      gm_q <= 64'(grav_q) * 64'(mi_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= ((cmd_i.step == '0) ? 118'd0 : prod_q) + pp_sh;
    end
    if (cmd_i.emit) begin
      out_q.kinetic     <= kin_q;
      out_q.potential   <= 48'd0 - mag;
      out_q.saturated   <= sat;
      out_q.last_result <= cmd_i.last;
    end
  end

`ifndef SYNTHESIS
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.saturated) |-> (out_q.potential == (48'd0 - PotLimit)))
    else $error("Saturated result without the limit potential.");

  a_pot_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.potential[47] || out_q.potential == '0))
    else $error("Positive potential energy.");
`endif

endmodule
`default_nettype wire

>>> hw/rtl/nbody_particle_energy.sv
`default_nettype none
// ----------------------------------------------------------------------------
// N-body particle energy
// Direct-summation kinetic and potential energy for a loaded particle set.
//
//   Channel  Handshake               Payload
//   input    in_valid_i/in_stall_o   in_i (npe_in_t)
//   output   out_valid_o/out_stall_i out_o (npe_out_t)
//   config   cfg_we_i                cfg_wdata_i (G, Q16.16)
//
// Loading accepts one particle per cycle; each particle of the loaded set then
// yields one result, each pair costing one pass of the bit-serial square root
// and the bit-serial divider. A coincident pair skips both and saturates the
// result. Input stall is high while a set is being evaluated. Reset clears the
// control state and sets G to one.
// ----------------------------------------------------------------------------
module nbody_particle_energy
  import npe_pkg::*;
#(
  parameter int unsigned MAX_PARTICLES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire npe_in_t     in_i,
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      npe_out_t    out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [31:0] cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_PARTICLES);

  logic            wr_en;
  logic [IdxW-1:0] wr_addr, rd_addr;
  npe_rec_t        wdata, rdata;
  npe_cmd_t        cmd;
  npe_status_t     status;

  assign wdata.mass     = in_i.mass;
  assign wdata.pos_x    = in_i.pos_x;
  assign wdata.pos_y    = in_i.pos_y;
  assign wdata.pos_z    = in_i.pos_z;
  assign wdata.speed_sq = in_i.speed_sq;

  npe_ram #(
    .Width($bits(npe_rec_t)),
    .Depth(MAX_PARTICLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wdata),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  npe_ctrl #(
    .MaxParticles(MAX_PARTICLES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_last_i (in_i.last_particle),
    .in_stall_o(in_stall_o),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .cmd_o     (cmd),
    .status_i  (status)
  );

  npe_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .rdata_i    (rdata),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

>>> dv/tb_nbody_particle_energy.sv
// ----------------------------------------------------------------------------
// N-body particle energy testbench
// Loads particle sets of random and extreme content into the block, predicts
// each particle's kinetic and potential energy with a fixed-point model kept
// in a scoreboard, and compares every result transaction in order. Sender and
// receiver idle at random in the first two of three phases; G is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_nbody_particle_energy;
  import npe_pkg::*;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned IdleLimit = 200000;
  localparam int unsigned DrainCycles = 200;

  class energy_scoreboard;
    logic [31:0] mass_q [NumSlots];
    logic [31:0] x_q [NumSlots];
    logic [31:0] y_q [NumSlots];
    logic [31:0] z_q [NumSlots];
    logic [31:0] speed_q [NumSlots];
    int unsigned loaded;
    logic [31:0] grav;
    npe_out_t energy_q [$];
    int unsigned errors;

    function new();
      loaded = 0;
      grav = GravReset;
      errors = 0;
    endfunction

    function automatic logic [63:0] root_floor(input logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
    endfunction

    function automatic logic [32:0] span(input logic [31:0] a, input logic [31:0] b);
      logic signed [33:0] d;
      d = 34'($signed(a)) - 34'($signed(b));
      return d < 0 ? 33'(-d) : 33'(d);
    endfunction

    function automatic logic [63:0] pair_dist(input int unsigned i, input int unsigned j);
      logic [127:0] sos;
      logic [32:0] dx, dy, dz;
      dx = span(x_q[i], x_q[j]);
      dy = span(y_q[i], y_q[j]);
      dz = span(z_q[i], z_q[j]);
      sos = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy) + 128'(dz) * 128'(dz);
      return root_floor(sos);
    endfunction

    function void note_input(input npe_in_t it);
      int unsigned slot;
      logic [63:0] sum, d, gm;
      logic [127:0] prod;
      logic [63:0] mag;
      npe_out_t res;
      slot = loaded >= NumSlots ? NumSlots - 1 : loaded;
      mass_q[slot] = it.mass;
      x_q[slot] = it.pos_x;
      y_q[slot] = it.pos_y;
      z_q[slot] = it.pos_z;
      speed_q[slot] = it.speed_sq;
      loaded = slot + 1;
      if (!it.last_particle && loaded < NumSlots) return;
      for (int unsigned i = 0; i < loaded; i++) begin
        sum = '0;
        res.saturated = 1'b0;
        for (int unsigned j = 0; j < loaded; j++) begin
          if (j == i) continue;
          d = pair_dist(i, j);
          if (d == 0) res.saturated = 1'b1;
          else sum += (64'(mass_q[j]) << 16) / d;
        end
        mag = '0;
        if (!res.saturated) begin
          gm = 64'(grav) * 64'(mass_q[i]);
          prod = 128'(gm) * 128'(sum);
          if (prod[127:96] != 0) res.saturated = 1'b1;
          else begin
            mag = prod[95:32];
            if (mag > 64'(PotLimit)) res.saturated = 1'b1;
          end
        end
        if (res.saturated) mag = 64'(PotLimit);
        res.kinetic = 48'((64'(mass_q[i]) * 64'(speed_q[i])) >> 17);
        res.potential = 48'(64'd0 - mag);
        res.last_result = (i + 1 == loaded);
        energy_q.push_back(res);
      end
      loaded = 0;
    endfunction

    task report_mismatch(input string what, input logic [47:0] got, input logic [47:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
    endtask

    task check_result(input npe_out_t got);
      npe_out_t want;
      if (energy_q.size() == 0) begin
        report_mismatch("unexpected result", 48'(got), '0);
        return;
      end
      want = energy_q.pop_front();
      if (got.kinetic !== want.kinetic) report_mismatch("kinetic", got.kinetic, want.kinetic);
      if (got.potential !== want.potential)
        report_mismatch("potential", got.potential, want.potential);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", 48'(got.saturated), 48'(want.saturated));
      if (got.last_result !== want.last_result)
        report_mismatch("last_result", 48'(got.last_result), 48'(want.last_result));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  npe_in_t in_i;
  logic out_valid_o;
  logic out_stall_i;
  npe_out_t out_o;
  logic cfg_we_i;
  logic [31:0] cfg_wdata_i;

  energy_scoreboard sb;
  int unsigned tx_idle;
  int unsigned rx_idle;
  int unsigned quiet_cycles;
  int unsigned sent;

  nbody_particle_energy u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_i(in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o(out_o),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("tb_nbody_particle_energy NOT OK");
        $finish;
      end
    end
  end

  task automatic send_particle(input npe_in_t it);
    while ($urandom_range(99) < tx_idle) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_i = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(it);
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.energy_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_grav(input logic [31:0] g);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = g;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.grav = g;
  endtask

  function automatic npe_in_t random_particle(input logic last);
    npe_in_t p;
    p.mass = $urandom_range(3) == 0 ? $urandom() : $urandom_range(32'h0004_0000);
    if ($urandom_range(1)) begin
      p.pos_x = $urandom();
      p.pos_y = $urandom();
      p.pos_z = $urandom();
    end else begin
      p.pos_x = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      p.pos_y = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      p.pos_z = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
    end
    p.speed_sq = $urandom_range(1) ? $urandom() : $urandom_range(32'h0004_0000);
    p.last_particle = last;
    return p;
  endfunction

  task automatic send_set(input int unsigned n);
    npe_in_t p;
    npe_in_t prev;
    for (int unsigned k = 0; k < n; k++) begin
      p = random_particle(k + 1 == n && n < NumSlots);
      if (k > 0 && $urandom_range(9) == 0) begin
        p.pos_x = prev.pos_x;
        p.pos_y = prev.pos_y;
        p.pos_z = prev.pos_z;
      end
      send_particle(p);
      prev = p;
    end
  endtask

  task automatic random_sets(input int unsigned items);
    int unsigned goal;
    goal = sent + items;
    while (sent < goal) send_set($urandom_range(7) == 0 ? $urandom_range(8, 12) : $urandom_range(1, 5));
  endtask

  task automatic directed();
    npe_in_t p;
    p = '{mass: '1, pos_x: 32'sh7fff_ffff, pos_y: 32'sh8000_0000, pos_z: '0,
          speed_sq: '1, last_particle: 1'b1};
    send_particle(p);
    p.last_particle = 1'b0;
    send_particle(p);
    p.pos_x = 32'sh8000_0000;
    p.pos_y = 32'sh7fff_ffff;
    p.pos_z = 32'sh7fff_ffff;
    p.last_particle = 1'b1;
    send_particle(p);
    p = '{mass: 32'h0001_0000, pos_x: 32'sh0001_0000, pos_y: '0, pos_z: '0,
          speed_sq: 32'h0001_0000, last_particle: 1'b0};
    send_particle(p);
    p.mass = '0;
    send_particle(p);
    p.pos_x = '0;
    p.speed_sq = '0;
    p.last_particle = 1'b1;
    send_particle(p);
    p = '{mass: 32'h0000_0001, pos_x: '0, pos_y: '0, pos_z: '0,
          speed_sq: 32'h0000_0001, last_particle: 1'b0};
    send_particle(p);
    p.pos_z = 32'sh0000_0001;
    p.last_particle = 1'b1;
    send_particle(p);
    send_set(3);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    tx_idle = 25;
    rx_idle = 68;
    sent = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed();
    write_grav('0);
    directed();
    write_grav('1);
    directed();
    random_sets(40);

    write_grav($urandom());
    tx_idle = 68;
    rx_idle = 25;
    random_sets(80);

    write_grav(GravReset);
    tx_idle = 0;
    rx_idle = 0;
    random_sets(30);
    send_set(NumSlots);
    random_sets(20);

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb_nbody_particle_energy OK");
    end else begin
      $display("tb_nbody_particle_energy NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/npe_pkg.sv
hw/rtl/npe_ram.sv
hw/rtl/npe_ctrl.sv
hw/rtl/npe_dp.sv
hw/rtl/nbody_particle_energy.sv
dv/tb_nbody_particle_energy.sv
